>>> sv/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg: shared types for the delimiter stream splitter
// Item payloads, configuration register codes, window cell operations and
// the per-cycle step record handed from the scanner to the output stage.
// ----------------------------------------------------------------------------
package dss_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_blob;
   } req_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       end_of_message;
      logic       run_last;
   } rsp_type;

   // Configuration port: 64-bit registers at byte addresses 8*i
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   // Register index, taken from address bit 3
   localparam logic REG_DELIMITER_LENGTH = 1'b0;
   localparam logic REG_DELIMITER_BYTES  = 1'b1;

   // Pattern bytes carried by the delimiter_bytes register
   localparam int PATTERN_BYTES = 8;

   // What each window cell loads at the next edge
   typedef enum logic [1:0] {
      CELL_KEEP,
      CELL_SHIFT_ONE,
      CELL_SHIFT_LEN
   } cell_op_type;

   // One scan step, as seen by the output stage
   typedef struct packed {
      logic       adv;
      logic       new_valid;
      logic [7:0] new_byte;
      logic       new_eom;
      logic       done;
   } step_type;

endpackage

>>> sv/dss_cell.sv
// ----------------------------------------------------------------------------
// dss_cell: one byte of the match window
// Holds a window byte, takes the incoming byte when it is the append slot,
// compares against its pattern byte and loads from a neighbor on a shift.
// ----------------------------------------------------------------------------
module dss_cell (
   input  logic                clock,
   input  logic                load_here,
   input  logic [7:0]          load_byte,
   input  logic [7:0]          near_byte,
   input  logic [7:0]          far_byte,
   input  logic [7:0]          pattern_byte,
   input  dss_pkg::cell_op_type op,
   output logic [7:0]          cur_byte,
   output logic                eq
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // Appended view: the new byte lands here in the same cycle it is scanned
   assign cur_byte = load_here ? load_byte : byte_ff;
   assign eq       = (cur_byte == pattern_byte);

   always_comb begin
      case (op)
         dss_pkg::CELL_KEEP:      byte_in = cur_byte;
         dss_pkg::CELL_SHIFT_ONE: byte_in = near_byte;
         dss_pkg::CELL_SHIFT_LEN: byte_in = far_byte;
         default:                 byte_in = cur_byte;
      endcase
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

>>> sv/dss_emit.sv
// ----------------------------------------------------------------------------
// dss_emit: result staging and output register
// Holds the newest result one step so its run_last mark is known, then
// moves it into the output register that faces the result channel.
// ----------------------------------------------------------------------------
module dss_emit (
   input  logic              clock,
   input  logic              reset,
   input  dss_pkg::step_type step,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output dss_pkg::rsp_type  rsp_data,
   output logic              out_free
);

   logic             pend_valid_ff, pend_valid_in;
   logic             pend_final_ff, pend_final_in;
   logic [7:0]       pend_byte_ff, pend_byte_in;
   logic             pend_eom_ff, pend_eom_in;
   logic             rsp_valid_ff, rsp_valid_in;
   dss_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic take_new;
   logic emit;
   logic last;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign take_new = step.adv && step.new_valid;
   // Release the staged result once its successor exists or its item is done
   assign emit = out_free && pend_valid_ff &&
                 (pend_final_ff || take_new || (step.adv && step.done));
   assign last = pend_final_ff || (step.adv && step.done && !step.new_valid);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_final_in = pend_final_ff;
      pend_byte_in  = pend_byte_ff;
      pend_eom_in   = pend_eom_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_data_in.payload_byte   = pend_byte_ff;
            rsp_data_in.end_of_message = pend_eom_ff;
            rsp_data_in.run_last       = last;
         end
      end
      if (take_new) begin
         pend_valid_in = 1'b1;
         pend_final_in = step.done;
         pend_byte_in  = step.new_byte;
         pend_eom_in   = step.new_eom;
      end else if (emit) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_final_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         pend_final_ff <= pend_final_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_byte_ff <= pend_byte_in;
      pend_eom_ff  <= pend_eom_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_adv_needs_slot : assert property (@(posedge clock) disable iff (reset)
      step.adv |-> out_free)
      else $error("scan advanced while output register was blocked");

   a_mid_run_queued : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.run_last) |-> pend_valid_ff)
      else $error("result without run_last has no successor staged");

endmodule

>>> sv/delimiter_stream_splitter_top.sv
// Throughput: one byte per cycle in steady state while rsp_stall is low, set by the one-result-per-cycle output stage.
// Blob end: req_stall holds while the held and windowed bytes flush, one result per cycle
// while rsp_stall is low.
// A byte that follows a shortened delimiter length rescans the window one step per cycle while rsp_stall is low.
// Reset (synchronous): empty window, nothing held, delimiter length zero (whole blob passes).
// ----------------------------------------------------------------------------
// delimiter_stream_splitter_top: split a byte blob into messages at a delimiter
// A row of window cells compares the newest bytes against the configured
// pattern in parallel; unmatched bytes leave through a single held byte.
// ----------------------------------------------------------------------------
module delimiter_stream_splitter_top #(
   parameter int DELIM_MAX = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // input items
   input  logic                             req_valid,
   output logic                             req_stall,
   input  dss_pkg::req_type                 req_data,
   // result items
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output dss_pkg::rsp_type                 rsp_data,
   // configuration
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dss_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [dss_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [dss_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   localparam int FILL_W = $clog2(DELIM_MAX + 1);
   localparam int SUM_W  = FILL_W + 1;
   localparam logic [4:0] MAX_WIDE = 5'(DELIM_MAX);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [3:0]  len_ff, len_in;
   logic [63:0] pat_ff, pat_in;
   logic        cfg_wr;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      len_in = len_ff;
      pat_in = pat_ff;
      if (cfg_wr) begin
         unique case (csr_paddr[3])
            dss_pkg::REG_DELIMITER_LENGTH: len_in = csr_pwdata[3:0];
            dss_pkg::REG_DELIMITER_BYTES:  pat_in = csr_pwdata;
            default:                       len_in = len_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3])
         dss_pkg::REG_DELIMITER_LENGTH: csr_prdata = 64'(len_ff);
         dss_pkg::REG_DELIMITER_BYTES:  csr_prdata = pat_ff;
         default:                       csr_prdata = '0;
      endcase
   end

   // Clamp the length to the window depth; length zero still scans one byte
   logic [4:0]        len_wide;
   logic [FILL_W-1:0] len_eff;
   logic [FILL_W-1:0] thresh;

   assign len_wide = {1'b0, len_ff};
   assign len_eff  = (len_wide > MAX_WIDE) ? MAX_WIDE[FILL_W-1:0] : len_wide[FILL_W-1:0];
   assign thresh   = (len_eff == '0) ? FILL_W'(1) : len_eff;

   // ---------------------------------------------------------------------
   // Scan state
   // ---------------------------------------------------------------------
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        held_ff, held_in;
   logic              held_valid_ff, held_valid_in;
   logic              busy_ff, busy_in;
   logic              eob_ff, eob_in;

   logic              out_free;
   logic              take;
   logic              step_en;
   logic              eob_a;
   logic [FILL_W-1:0] fill_a;

   // Take a byte only when no earlier byte still needs steps
   assign take      = !busy_ff && req_valid && out_free;
   assign step_en   = out_free && (busy_ff || take);
   assign req_stall = busy_ff || !out_free;
   assign eob_a     = busy_ff ? eob_ff : req_data.end_of_blob;
   assign fill_a    = fill_ff + FILL_W'(take);

   // ---------------------------------------------------------------------
   // Window cells
   // ---------------------------------------------------------------------
   logic [7:0]           cur_b   [DELIM_MAX];
   logic [7:0]           near_b  [DELIM_MAX];
   logic [7:0]           far_b   [DELIM_MAX];
   logic [7:0]           pat_b   [DELIM_MAX];
   logic [DELIM_MAX-1:0] eq;
   logic [DELIM_MAX-1:0] load_here;
   dss_pkg::cell_op_type step_op;
   dss_pkg::cell_op_type cell_op;

   assign cell_op = step_en ? step_op : dss_pkg::CELL_KEEP;

   for (genvar i = 0; i < DELIM_MAX; i++) begin : g_cell
      if (i < dss_pkg::PATTERN_BYTES) begin : g_pat
         assign pat_b[i] = pat_ff[8*i +: 8];
      end else begin : g_zero
         // pattern bytes beyond the register read as zero
         assign pat_b[i] = '0;
      end
      if (i + 1 < DELIM_MAX) begin : g_near
         assign near_b[i] = cur_b[i+1];
      end else begin : g_end
         assign near_b[i] = '0;
      end
      assign load_here[i] = take && (fill_ff == FILL_W'(i));

      dss_cell u_cell (
         .clock        (clock),
         .load_here    (load_here[i]),
         .load_byte    (req_data.data_byte),
         .near_byte    (near_b[i]),
         .far_byte     (far_b[i]),
         .pattern_byte (pat_b[i]),
         .op           (cell_op),
         .cur_byte     (cur_b[i]),
         .eq           (eq[i])
      );
   end

   // Source for a drop of the whole delimiter: the byte len_eff places on
   always_comb begin
      for (int i = 0; i < DELIM_MAX; i++) begin
         far_b[i] = '0;
         for (int j = 0; j < DELIM_MAX; j++) begin
            if (SUM_W'(j) == SUM_W'(i) + SUM_W'(len_eff)) begin
               far_b[i] = cur_b[j];
            end
         end
      end
   end

   // Parallel compare of the leading len_eff window bytes
   logic hit_all;
   logic hit;

   always_comb begin
      hit_all = 1'b1;
      for (int i = 0; i < DELIM_MAX; i++) begin
         if ((FILL_W'(i) < len_eff) && !eq[i]) begin
            hit_all = 1'b0;
         end
      end
   end

   assign hit = (len_eff != '0) && hit_all;

   // ---------------------------------------------------------------------
   // One step: a match check when the window is full enough, otherwise one
   // flush result at blob end
   // ---------------------------------------------------------------------
   logic              scan;
   logic              flush;
   logic [FILL_W-1:0] step_fill;
   logic [7:0]        step_held;
   logic              step_held_valid;
   logic              step_done;
   dss_pkg::step_type step;

   assign scan  = (fill_a >= thresh);
   assign flush = !scan && eob_a && (held_valid_ff || (fill_a != '0));

   always_comb begin
      step_fill       = fill_a;
      step_held       = held_ff;
      step_held_valid = held_valid_ff;
      step_op         = dss_pkg::CELL_KEEP;
      step.adv        = step_en;
      step.new_valid  = 1'b0;
      step.new_byte   = held_ff;
      step.new_eom    = 1'b0;
      if (scan) begin
         step.new_valid = held_valid_ff;
         if (hit) begin
            // drop the delimiter, close the message on the held byte
            step.new_eom    = 1'b1;
            step_held_valid = 1'b0;
            step_fill       = fill_a - len_eff;
            step_op         = dss_pkg::CELL_SHIFT_LEN;
         end else begin
            // release the held byte, hold the oldest window byte
            step_held       = cur_b[0];
            step_held_valid = 1'b1;
            step_fill       = fill_a - FILL_W'(1);
            step_op         = dss_pkg::CELL_SHIFT_ONE;
         end
      end else if (flush) begin
         step.new_valid = 1'b1;
         if (held_valid_ff) begin
            step.new_eom    = (fill_a == '0);
            step_held_valid = 1'b0;
         end else begin
            step.new_byte = cur_b[0];
            step.new_eom  = (fill_a == FILL_W'(1));
            step_fill     = fill_a - FILL_W'(1);
            step_op       = dss_pkg::CELL_SHIFT_ONE;
         end
      end
      // Done when no further check or flush result is due; at blob end this
      // leaves the window empty with nothing held
      step_done = !(step_fill >= thresh) &&
                  !(eob_a && (step_held_valid || (step_fill != '0)));
      step.done = step_done;
   end

   always_comb begin
      fill_in       = fill_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      busy_in       = busy_ff;
      eob_in        = eob_ff;
      if (step_en) begin
         fill_in       = step_fill;
         held_in       = step_held;
         held_valid_in = step_held_valid;
         busy_in       = !step_done;
         eob_in        = eob_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         pat_ff        <= '0;
         fill_ff       <= '0;
         held_valid_ff <= 1'b0;
         busy_ff       <= 1'b0;
         eob_ff        <= 1'b0;
      end else begin
         len_ff        <= len_in;
         pat_ff        <= pat_in;
         fill_ff       <= fill_in;
         held_valid_ff <= held_valid_in;
         busy_ff       <= busy_in;
         eob_ff        <= eob_in;
      end
      held_ff <= held_in;
   end

   // ---------------------------------------------------------------------
   // Output staging
   // ---------------------------------------------------------------------
   dss_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .out_free  (out_free)
   );

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(DELIM_MAX))
      else $error("window fill beyond window depth");

   a_blob_clears : assert property (@(posedge clock) disable iff (reset)
      (step_en && step_done && eob_a) |=> (fill_ff == '0) && !held_valid_ff)
      else $error("state not cleared after blob end");

endmodule
